[rtl/rap_pkg.sv]
// ---------------------------------------------------------------------------
// rap_pkg
// Types, constants and helper functions shared by the router advertisement
// parser modules.
// ---------------------------------------------------------------------------
package rap_pkg;

    // message limits and header layout
    localparam int MAX_MESSAGE_BYTES = 2048;
    localparam int OFFSET_W          = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int OPT_OFF_W         = 11;
    localparam int HEADER_BYTES      = 16;
    localparam int OFF_FLAGS         = 5;
    localparam int OFF_LIFE_FIRST    = 6;
    localparam int OFF_LIFE_END      = 8;
    localparam int OFF_REACH_END     = 12;

    // message and option type codes
    localparam logic [7:0] RA_TYPE    = 8'd134;
    localparam logic [7:0] OPT_PREFIX = 8'd3;
    localparam logic [7:0] OPT_DNS    = 8'd25;

    // option layout
    localparam int PREFIX_LEN_OFF  = 2;
    localparam int PREFIX_ADDR_OFF = 16;
    localparam int DNS_ADDR_OFF    = 8;
    localparam int DNS_MIN_BYTES   = 24;
    localparam int ADDR_BYTES      = 16;

    // status bit positions
    localparam int ST_PREFIX = 0;
    localparam int ST_DNS    = 1;
    localparam int ST_BAD    = 2;

    // summary queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_LINK_LOCAL_HIGH = 1'b0,
        REG_LINK_LOCAL_LOW  = 1'b1
    } rap_reg_e;

    // record kinds, emitted in this order
    typedef enum logic [2:0] {
        KIND_TIMING   = 3'd0,
        KIND_ADDR_HI  = 3'd1,
        KIND_ADDR_LO  = 3'd2,
        KIND_DNS_HI   = 3'd3,
        KIND_DNS_LO   = 3'd4
    } rap_kind_e;

    // one input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } rap_in_t;

    // one result request
    typedef struct packed {
        logic [2:0]  record_kind;
        logic [63:0] data;
        logic [7:0]  ra_flags;
        logic [15:0] lifetime_secs;
        logic [1:0]  managed_other;
        logic        prefix_seen;
        logic        dns_seen;
        logic        malformed;
        logic        last_record;
    } rap_out_t;

    // everything the back end needs to emit the records of one message
    typedef struct packed {
        logic [63:0] timing;
        logic [63:0] gaddr_hi;
        logic [63:0] gaddr_lo;
        logic [63:0] dns_hi;
        logic [63:0] dns_lo;
        logic [7:0]  flags;
        logic [15:0] lifetime;
        logic [2:0]  status;
    } rap_summary_t;

    // ones over the top n bytes of a 64-bit half, n in 0..8
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            m[63 - 8*i -: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // replace byte pos (0 is the top byte) of a 64-bit half
    function automatic logic [63:0] put_byte(input logic [63:0] half,
                                             input logic [2:0]  pos,
                                             input logic [7:0]  b);
        logic [63:0] r;
        r = half;
        for (int i = 0; i < 8; i++)
        begin
            if (pos == 3'(i))
            begin
                r[63 - 8*i -: 8] = b;
            end
        end
        return r;
    endfunction

endpackage

[rtl/rap_front.sv]
// ---------------------------------------------------------------------------
// rap_front
// Byte-serial parser: walks the advertisement header and options, one byte
// per cycle while accept is high; an advert's last byte queues its summary.
// ---------------------------------------------------------------------------
module rap_front
    import rap_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  rap_in_t      in_item,
    input  logic         cfg_write,
    input  rap_reg_e     cfg_index,
    input  logic [63:0]  cfg_data,
    output logic         sum_push,
    output rap_summary_t sum_data
);

    logic [63:0]          ll_high_reg, ll_high_next;
    logic [63:0]          ll_low_reg, ll_low_next;
    logic [OFFSET_W-1:0]  byte_off_reg, byte_off_next;
    logic                 is_advert_reg, is_advert_next;
    logic [OPT_OFF_W-1:0] opt_off_reg, opt_off_next;
    logic [7:0]           opt_kind_reg, opt_kind_next;
    logic [OPT_OFF_W-1:0] opt_bytes_reg, opt_bytes_next;
    logic [7:0]           flags_reg, flags_next;
    logic [15:0]          life_reg, life_next;
    logic [31:0]          reach_reg, reach_next;
    logic [31:0]          retrans_reg, retrans_next;
    logic [7:0]           pfx_bits_reg, pfx_bits_next;
    logic [63:0]          scr_hi_reg, scr_hi_next;
    logic [63:0]          scr_lo_reg, scr_lo_next;
    logic [63:0]          gaddr_hi_reg, gaddr_hi_next;
    logic [63:0]          gaddr_lo_reg, gaddr_lo_next;
    logic [63:0]          dns_hi_reg, dns_hi_next;
    logic [63:0]          dns_lo_reg, dns_lo_next;
    logic [2:0]           status_reg, status_next;

    logic [7:0]           b;
    logic [OFFSET_W-1:0]  o;
    logic [OPT_OFF_W-1:0] dns_pos;
    logic [4:0]           pfx_n;
    logic [3:0]           n_hi;
    logic [3:0]           n_lo;
    logic [63:0]          m_hi;
    logic [63:0]          m_lo;
    logic                 opt_done;

    assign b = in_item.data_byte;
    assign o = byte_off_reg;
    assign dns_pos = opt_off_reg - OPT_OFF_W'(DNS_ADDR_OFF);

    // prefix byte count, capped at a full address, split over the halves
    // (the prefix length byte is always registered before an option closes)
    always_comb
    begin
        pfx_n = (pfx_bits_reg[7:3] > 5'(ADDR_BYTES)) ? 5'(ADDR_BYTES) : pfx_bits_reg[7:3];
        n_hi  = (pfx_n > 5'd8) ? 4'd8 : pfx_n[3:0];
        n_lo  = (pfx_n > 5'd8) ? 4'(pfx_n - 5'd8) : 4'd0;
        m_hi  = byte_mask(n_hi);
        m_lo  = byte_mask(n_lo);
    end

    // parser next state
    always_comb
    begin
        ll_high_next   = ll_high_reg;
        ll_low_next    = ll_low_reg;
        byte_off_next  = byte_off_reg;
        is_advert_next = is_advert_reg;
        opt_off_next   = opt_off_reg;
        opt_kind_next  = opt_kind_reg;
        opt_bytes_next = opt_bytes_reg;
        flags_next     = flags_reg;
        life_next      = life_reg;
        reach_next     = reach_reg;
        retrans_next   = retrans_reg;
        pfx_bits_next  = pfx_bits_reg;
        scr_hi_next    = scr_hi_reg;
        scr_lo_next    = scr_lo_reg;
        gaddr_hi_next  = gaddr_hi_reg;
        gaddr_lo_next  = gaddr_lo_reg;
        dns_hi_next    = dns_hi_reg;
        dns_lo_next    = dns_lo_reg;
        status_next    = status_reg;
        opt_done       = 1'b0;
        sum_push       = 1'b0;

        // configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LINK_LOCAL_HIGH: ll_high_next = cfg_data;
                REG_LINK_LOCAL_LOW:  ll_low_next  = cfg_data;
                default:             ll_low_next  = ll_low_reg;
            endcase
        end

        if (accept)
        begin
            // bytes past the size limit are ignored
            if (o < OFFSET_W'(MAX_MESSAGE_BYTES))
            begin
                byte_off_next = o + OFFSET_W'(1);
                if (o == '0)
                begin
                    // message start clears the header fields and status
                    is_advert_next = (b == RA_TYPE);
                    flags_next     = '0;
                    life_next      = '0;
                    reach_next     = '0;
                    retrans_next   = '0;
                    status_next    = '0;
                    opt_off_next   = '0;
                end
                else if (is_advert_reg)
                begin
                    if (o == OFFSET_W'(OFF_FLAGS))
                    begin
                        flags_next = b;
                    end
                    else if (o >= OFFSET_W'(OFF_LIFE_FIRST) && o < OFFSET_W'(OFF_LIFE_END))
                    begin
                        life_next = {life_reg[7:0], b};
                    end
                    else if (o >= OFFSET_W'(OFF_LIFE_END) && o < OFFSET_W'(OFF_REACH_END))
                    begin
                        reach_next = {reach_reg[23:0], b};
                    end
                    else if (o >= OFFSET_W'(OFF_REACH_END) && o < OFFSET_W'(HEADER_BYTES))
                    begin
                        retrans_next = {retrans_reg[23:0], b};
                    end
                    else if (o >= OFFSET_W'(HEADER_BYTES) && !status_reg[ST_BAD])
                    begin
                        // option walk
                        if (opt_off_reg == '0)
                        begin
                            opt_kind_next = b;
                            opt_off_next  = OPT_OFF_W'(1);
                        end
                        else if (opt_off_reg == OPT_OFF_W'(1))
                        begin
                            opt_bytes_next = {b, 3'b000};
                            if (b == 8'd0)
                            begin
                                status_next[ST_BAD] = 1'b1;
                                opt_off_next        = '0;
                            end
                            else
                            begin
                                opt_off_next = OPT_OFF_W'(2);
                            end
                        end
                        else
                        begin
                            // capture prefix length and address bytes
                            if (opt_kind_reg == OPT_PREFIX)
                            begin
                                if (opt_off_reg == OPT_OFF_W'(PREFIX_LEN_OFF))
                                begin
                                    pfx_bits_next = b;
                                end
                                else if (opt_off_reg >= OPT_OFF_W'(PREFIX_ADDR_OFF) &&
                                         opt_off_reg < OPT_OFF_W'(PREFIX_ADDR_OFF + ADDR_BYTES))
                                begin
                                    if (opt_off_reg[3])
                                        scr_lo_next = put_byte(scr_lo_reg, opt_off_reg[2:0], b);
                                    else
                                        scr_hi_next = put_byte(scr_hi_reg, opt_off_reg[2:0], b);
                                end
                            end
                            else if (opt_kind_reg == OPT_DNS)
                            begin
                                if (opt_off_reg >= OPT_OFF_W'(DNS_ADDR_OFF) &&
                                    opt_off_reg < OPT_OFF_W'(DNS_ADDR_OFF + ADDR_BYTES))
                                begin
                                    if (dns_pos[3])
                                        scr_lo_next = put_byte(scr_lo_reg, dns_pos[2:0], b);
                                    else
                                        scr_hi_next = put_byte(scr_hi_reg, dns_pos[2:0], b);
                                end
                            end

                            // end of option
                            if ({1'b0, opt_off_reg} + 12'd1 >= {1'b0, opt_bytes_reg})
                            begin
                                opt_done     = 1'b1;
                                opt_off_next = '0;
                            end
                            else
                            begin
                                opt_off_next = opt_off_reg + OPT_OFF_W'(1);
                            end
                        end
                    end
                end
            end

            // commit a finished prefix or dns option
            if (opt_done)
            begin
                if (opt_kind_reg == OPT_PREFIX)
                begin
                    if ({1'b0, opt_bytes_reg} < 12'(PREFIX_ADDR_OFF) + 12'(pfx_n))
                    begin
                        status_next[ST_BAD] = 1'b1;
                    end
                    else
                    begin
                        gaddr_hi_next = (scr_hi_next & m_hi) | (ll_high_reg & ~m_hi);
                        gaddr_lo_next = (scr_lo_next & m_lo) | (ll_low_reg & ~m_lo);
                        status_next[ST_PREFIX] = 1'b1;
                    end
                end
                else if (opt_kind_reg == OPT_DNS)
                begin
                    if (opt_bytes_reg < OPT_OFF_W'(DNS_MIN_BYTES))
                    begin
                        status_next[ST_BAD] = 1'b1;
                    end
                    else
                    begin
                        dns_hi_next = scr_hi_next;
                        dns_lo_next = scr_lo_next;
                        status_next[ST_DNS] = 1'b1;
                    end
                end
            end

            // message end: short header or open option is malformed
            if (in_item.last)
            begin
                if (is_advert_next)
                begin
                    if (o < OFFSET_W'(HEADER_BYTES - 1) || opt_off_next != '0)
                    begin
                        status_next[ST_BAD] = 1'b1;
                    end
                    sum_push = 1'b1;
                end
                byte_off_next  = '0;
                is_advert_next = 1'b0;
                opt_off_next   = '0;
            end
        end
    end

    // summary handed to the queue
    always_comb
    begin
        sum_data.timing   = {reach_next, retrans_next};
        sum_data.gaddr_hi = gaddr_hi_next;
        sum_data.gaddr_lo = gaddr_lo_next;
        sum_data.dns_hi   = dns_hi_next;
        sum_data.dns_lo   = dns_lo_next;
        sum_data.flags    = flags_next;
        sum_data.lifetime = life_next;
        sum_data.status   = status_next;
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ll_high_reg   <= '0;
            ll_low_reg    <= '0;
            byte_off_reg  <= '0;
            is_advert_reg <= 1'b0;
            opt_off_reg   <= '0;
            opt_kind_reg  <= '0;
            opt_bytes_reg <= '0;
            flags_reg     <= '0;
            life_reg      <= '0;
            reach_reg     <= '0;
            retrans_reg   <= '0;
            pfx_bits_reg  <= '0;
            scr_hi_reg    <= '0;
            scr_lo_reg    <= '0;
            gaddr_hi_reg  <= '0;
            gaddr_lo_reg  <= '0;
            dns_hi_reg    <= '0;
            dns_lo_reg    <= '0;
            status_reg    <= '0;
        end
        else
        begin
            ll_high_reg   <= ll_high_next;
            ll_low_reg    <= ll_low_next;
            byte_off_reg  <= byte_off_next;
            is_advert_reg <= is_advert_next;
            opt_off_reg   <= opt_off_next;
            opt_kind_reg  <= opt_kind_next;
            opt_bytes_reg <= opt_bytes_next;
            flags_reg     <= flags_next;
            life_reg      <= life_next;
            reach_reg     <= reach_next;
            retrans_reg   <= retrans_next;
            pfx_bits_reg  <= pfx_bits_next;
            scr_hi_reg    <= scr_hi_next;
            scr_lo_reg    <= scr_lo_next;
            gaddr_hi_reg  <= gaddr_hi_next;
            gaddr_lo_reg  <= gaddr_lo_next;
            dns_hi_reg    <= dns_hi_next;
            dns_lo_reg    <= dns_lo_next;
            status_reg    <= status_next;
        end
    end

`ifndef SYNTHESIS
    // the byte offset never passes the size limit
    a_off_limit: assert property (@(posedge clk) disable iff (!rst_n)
        byte_off_reg <= OFFSET_W'(MAX_MESSAGE_BYTES))
        else $error("byte offset beyond limit");

    // a message end always returns the parser to the start of a message
    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_item.last |=> byte_off_reg == '0 && opt_off_reg == '0)
        else $error("parser not restarted after last byte");
`endif

endmodule

[rtl/rap_queue.sv]
// ---------------------------------------------------------------------------
// rap_queue
// Short queue of message summaries between the parser and record emitter.
// ---------------------------------------------------------------------------
module rap_queue
    import rap_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  rap_summary_t wr_data,
    output logic         full,
    input  logic         pop,
    output rap_summary_t rd_data,
    output logic         empty
);

    rap_summary_t             store_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = store_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // summary storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    // no summary is written into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("summary queue overflow");

    // no summary is taken from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("summary queue underflow");
`endif

endmodule

[rtl/rap_back.sv]
// ---------------------------------------------------------------------------
// rap_back
// Record emitter: turns each queued summary into five records, one per
// cycle while the output is free or popped, through a single output register.
// ---------------------------------------------------------------------------
module rap_back
    import rap_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rap_summary_t q_data,
    input  logic         q_empty,
    output logic         q_pop,
    output logic         empty,
    input  logic         pop,
    output rap_out_t     result
);

    rap_kind_e rec_idx_reg, rec_idx_next;
    logic      out_valid_reg, out_valid_next;
    rap_out_t  out_reg, out_next;
    logic      load;

    assign load  = !q_empty && (!out_valid_reg || pop);
    assign q_pop = load && (rec_idx_reg == KIND_DNS_LO);
    assign empty = !out_valid_reg;
    assign result = out_reg;

    // record selection and output register load
    always_comb
    begin
        rec_idx_next   = rec_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next           = 1'b1;
            out_next.record_kind     = rec_idx_reg;
            out_next.ra_flags        = q_data.flags;
            out_next.lifetime_secs   = q_data.lifetime;
            out_next.managed_other   = q_data.flags[7:6];
            out_next.prefix_seen     = q_data.status[ST_PREFIX];
            out_next.dns_seen        = q_data.status[ST_DNS];
            out_next.malformed       = q_data.status[ST_BAD];
            out_next.last_record     = (rec_idx_reg == KIND_DNS_LO);
            case (rec_idx_reg)
                KIND_TIMING:  out_next.data = q_data.timing;
                KIND_ADDR_HI: out_next.data = q_data.gaddr_hi;
                KIND_ADDR_LO: out_next.data = q_data.gaddr_lo;
                KIND_DNS_HI:  out_next.data = q_data.dns_hi;
                KIND_DNS_LO:  out_next.data = q_data.dns_lo;
                default:      out_next.data = q_data.timing;
            endcase
            rec_idx_next = (rec_idx_reg == KIND_DNS_LO) ?
                           KIND_TIMING : rap_kind_e'(rec_idx_reg + 3'd1);
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_idx_reg   <= KIND_TIMING;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rec_idx_reg   <= rec_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    // the final record of a run is always the dns low half
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.last_record |-> out_reg.record_kind == KIND_DNS_LO)
        else $error("last_record on wrong kind");

    // a run in progress keeps its summary at the queue head
    a_run_head: assert property (@(posedge clk) disable iff (!rst_n)
        rec_idx_reg != KIND_TIMING |-> !q_empty)
        else $error("record run lost its summary");

    // records of one run come out in kind order
    a_kind_order: assert property (@(posedge clk) disable iff (!rst_n)
        load && rec_idx_reg != KIND_TIMING |->
            out_reg.record_kind == 3'(rec_idx_reg - 3'd1))
        else $error("record kinds out of order");
`endif

endmodule

[rtl/router_advert_parser.sv]
// ---------------------------------------------------------------------------
// router_advert_parser
// Byte-serial ICMPv6 router advertisement parser with queue-style ports.
// ---------------------------------------------------------------------------
// Usage:
//   Input: one message byte per request on in_item, taken when push is high
//   and full is low; in_item.last marks the final byte of a message.
//   Output: while empty is low the oldest record is on result; pop takes it.
//   A router advertisement gives five records (timings, global address
//   high/low, dns high/low) on its last byte; other messages give none.
//   Config: cfg_valid/cfg_ready writes the link-local halves, ready always
//   high; write only while no message is in flight.
// Timing:
//   One byte per cycle sustained while full is low, the parser state
//   updating on every byte taken. The last byte's summary is written into
//   the queue, and its first record then into the output register behind
//   result; the rest follow one per cycle while pop stays high.
//   The parser and emitter are split by a two-entry summary queue; full
//   is high while both entries wait, e.g. when the receiver stalls pop or
//   one-byte messages arrive faster than five records each drain.
// Reset: clears parser state, addresses, link-local registers and queues.
// ---------------------------------------------------------------------------
module router_advert_parser
    import rap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  rap_in_t     in_item,
    output logic        empty,
    input  logic        pop,
    output rap_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  rap_reg_e    cfg_index,
    input  logic [63:0] cfg_data
);

    logic         accept;
    logic         sum_push;
    rap_summary_t sum_data;
    rap_summary_t q_data;
    logic         q_empty;
    logic         q_pop;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // parser front end
    rap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_item   (in_item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sum_push  (sum_push),
        .sum_data  (sum_data)
    );

    // summary queue
    rap_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (sum_push),
        .wr_data (sum_data),
        .full    (full),
        .pop     (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    // record emitter
    rap_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

[sim/rap_tb_pkg.sv]
// ---------------------------------------------------------------------------
// rap_tb_pkg
// Scoreboard for the router advertisement parser bench: tracks the parser
// state byte by byte, queues the five records each advertisement should
// give and checks every popped record against the oldest one queued.
// ---------------------------------------------------------------------------
package rap_tb_pkg;

    import rap_pkg::*;

    class advert_scoreboard;

        // link-local halves as last written
        logic [63:0] link_hi;
        logic [63:0] link_lo;

        // message walk
        int unsigned msg_pos;
        bit          ra_msg;
        int unsigned opt_pos;
        logic [7:0]  opt_type;
        int unsigned opt_len;

        // header fields of the current message
        logic [7:0]  flags_byte;
        logic [15:0] lifetime;
        logic [31:0] reachable;
        logic [31:0] retrans;
        logic [7:0]  pfx_length;

        // addresses; scratch holds option bytes until the option closes
        logic [63:0] scratch [2];
        logic [63:0] gaddr [2];
        logic [63:0] dns_addr [2];

        bit saw_prefix;
        bit saw_dns;
        bit bad;

        rap_out_t pending_records [$];
        int       records_made;
        int       errors;

        function new();
            link_hi = '0;
            link_lo = '0;
            msg_pos = 0;
            ra_msg = 1'b0;
            opt_pos = 0;
            opt_type = '0;
            opt_len = 0;
            flags_byte = '0;
            lifetime = '0;
            reachable = '0;
            retrans = '0;
            pfx_length = '0;
            scratch[0] = '0;
            scratch[1] = '0;
            gaddr[0] = '0;
            gaddr[1] = '0;
            dns_addr[0] = '0;
            dns_addr[1] = '0;
            saw_prefix = 1'b0;
            saw_dns = 1'b0;
            bad = 1'b0;
            records_made = 0;
            errors = 0;
        endfunction

        function void write_reg(rap_reg_e idx, logic [63:0] value);
            case (idx)
                REG_LINK_LOCAL_HIGH: link_hi = value;
                REG_LINK_LOCAL_LOW:  link_lo = value;
                default: ;
            endcase
        endfunction

        // ones over the top n bytes of a half
        function logic [63:0] top_bytes(int unsigned n);
            if (n == 0)
            begin
                return '0;
            end
            if (n >= 8)
            begin
                return '1;
            end
            return {64{1'b1}} << ((8 - n) * 8);
        endfunction

        // byte p of the 16-byte address, p = 0 is the top byte
        function void store_scratch(int unsigned p, logic [7:0] b);
            scratch[(p >> 3) & 1][63 - 8 * (p & 7) -: 8] = b;
        endfunction

        // option complete: commit the address if it was long enough
        function void close_option();
            int unsigned n;
            logic [63:0] mask_hi;
            logic [63:0] mask_lo;
            if (opt_type == OPT_PREFIX)
            begin
                n = pfx_length >> 3;
                if (n > ADDR_BYTES)
                begin
                    n = ADDR_BYTES;
                end
                if (opt_len < PREFIX_ADDR_OFF + n)
                begin
                    bad = 1'b1;
                    return;
                end
                mask_hi = top_bytes((n > 8) ? 8 : n);
                mask_lo = top_bytes((n > 8) ? n - 8 : 0);
                gaddr[0] = (scratch[0] & mask_hi) | (link_hi & ~mask_hi);
                gaddr[1] = (scratch[1] & mask_lo) | (link_lo & ~mask_lo);
                saw_prefix = 1'b1;
            end
            else if (opt_type == OPT_DNS)
            begin
                if (opt_len < DNS_MIN_BYTES)
                begin
                    bad = 1'b1;
                    return;
                end
                dns_addr[0] = scratch[0];
                dns_addr[1] = scratch[1];
                saw_dns = 1'b1;
            end
        endfunction

        // one byte of the option area
        function void option_step(logic [7:0] b);
            if (bad)
            begin
                return;
            end
            if (opt_pos == 0)
            begin
                opt_type = b;
                opt_pos = 1;
                return;
            end
            if (opt_pos == 1)
            begin
                opt_len = int'(b) * 8;
                if (opt_len == 0)
                begin
                    bad = 1'b1;
                    opt_pos = 0;
                end
                else
                begin
                    opt_pos = 2;
                end
                return;
            end
            if (opt_type == OPT_PREFIX)
            begin
                if (opt_pos == PREFIX_LEN_OFF)
                begin
                    pfx_length = b;
                end
                else if (opt_pos >= PREFIX_ADDR_OFF && opt_pos < PREFIX_ADDR_OFF + ADDR_BYTES)
                begin
                    store_scratch(opt_pos - PREFIX_ADDR_OFF, b);
                end
            end
            else if (opt_type == OPT_DNS)
            begin
                if (opt_pos >= DNS_ADDR_OFF && opt_pos < DNS_ADDR_OFF + ADDR_BYTES)
                begin
                    store_scratch(opt_pos - DNS_ADDR_OFF, b);
                end
            end
            if (opt_pos + 1 >= opt_len)
            begin
                close_option();
                opt_pos = 0;
            end
            else
            begin
                opt_pos++;
            end
        endfunction

        // one byte at the current message offset
        function void message_step(logic [7:0] b);
            if (msg_pos == 0)
            begin
                ra_msg = (b == RA_TYPE);
                flags_byte = '0;
                lifetime = '0;
                reachable = '0;
                retrans = '0;
                saw_prefix = 1'b0;
                saw_dns = 1'b0;
                bad = 1'b0;
                opt_pos = 0;
                return;
            end
            if (!ra_msg)
            begin
                return;
            end
            if (msg_pos == OFF_FLAGS)
            begin
                flags_byte = b;
            end
            else if (msg_pos >= OFF_LIFE_FIRST && msg_pos < OFF_LIFE_END)
            begin
                lifetime = {lifetime[7:0], b};
            end
            else if (msg_pos >= OFF_LIFE_END && msg_pos < OFF_REACH_END)
            begin
                reachable = {reachable[23:0], b};
            end
            else if (msg_pos >= OFF_REACH_END && msg_pos < HEADER_BYTES)
            begin
                retrans = {retrans[23:0], b};
            end
            else if (msg_pos >= HEADER_BYTES)
            begin
                option_step(b);
            end
        endfunction

        // accepted input request; queues the records a final byte gives
        function void take_byte(rap_in_t req);
            int unsigned end_pos;
            rap_kind_e   order [5];
            logic [63:0] vals [5];
            rap_out_t    rec;
            end_pos = msg_pos;
            if (msg_pos < MAX_MESSAGE_BYTES)
            begin
                message_step(req.data_byte);
                msg_pos++;
            end
            if (!req.last)
            begin
                return;
            end
            if (ra_msg)
            begin
                if (end_pos < HEADER_BYTES - 1)
                begin
                    bad = 1'b1;
                end
                if (opt_pos != 0)
                begin
                    bad = 1'b1;
                end
                order[0] = KIND_TIMING;
                order[1] = KIND_ADDR_HI;
                order[2] = KIND_ADDR_LO;
                order[3] = KIND_DNS_HI;
                order[4] = KIND_DNS_LO;
                vals[0] = {reachable, retrans};
                vals[1] = gaddr[0];
                vals[2] = gaddr[1];
                vals[3] = dns_addr[0];
                vals[4] = dns_addr[1];
                for (int k = 0; k < 5; k++)
                begin
                    rec.record_kind     = order[k];
                    rec.data            = vals[k];
                    rec.ra_flags        = flags_byte;
                    rec.lifetime_secs   = lifetime;
                    rec.managed_other   = flags_byte[7:6];
                    rec.prefix_seen     = saw_prefix;
                    rec.dns_seen        = saw_dns;
                    rec.malformed       = bad;
                    rec.last_record     = (order[k] == KIND_DNS_LO);
                    pending_records.push_back(rec);
                    records_made++;
                end
            end
            msg_pos = 0;
            ra_msg = 1'b0;
            opt_pos = 0;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // popped result request against the oldest expected record
        function void check_record(rap_out_t got);
            rap_out_t want;
            if (pending_records.size() == 0)
            begin
                $error("record kind %0d popped with none expected", got.record_kind);
                errors++;
                return;
            end
            want = pending_records.pop_front();
            compare_field("record_kind", want.record_kind, got.record_kind);
            compare_field("data", want.data, got.data);
            compare_field("ra_flags", want.ra_flags, got.ra_flags);
            compare_field("lifetime_secs", want.lifetime_secs, got.lifetime_secs);
            compare_field("managed_other", want.managed_other, got.managed_other);
            compare_field("prefix_seen", want.prefix_seen, got.prefix_seen);
            compare_field("dns_seen", want.dns_seen, got.dns_seen);
            compare_field("malformed", want.malformed, got.malformed);
            compare_field("last_record", want.last_record, got.last_record);
        endfunction

        function int pending();
            return pending_records.size();
        endfunction

    endclass

endpackage

[sim/tb_router_advert_parser.sv]
// ---------------------------------------------------------------------------
// tb_router_advert_parser
// Drives ICMPv6 messages byte by byte into the router advertisement parser
// and checks every popped record against a scoreboard that walks the same
// message. Covers short and broken messages, prefix and dns options,
// three idle mixes and a long receiver stall.
// ---------------------------------------------------------------------------
module tb_router_advert_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import rap_pkg::*;
    import rap_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int TX_IDLE_LOW  = 21;
    localparam int RX_IDLE_HIGH = 45;

    typedef logic [7:0] byte_q [$];

    typedef enum logic [1:0] {
        PH_RX_HEAVY,
        PH_TX_HEAVY,
        PH_STREAM
    } tb_phase_e;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    rap_in_t     in_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    rap_out_t    result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    rap_reg_e    cfg_index = REG_LINK_LOCAL_HIGH;
    logic [63:0] cfg_data = '0;

    tb_phase_e        phase = PH_RX_HEAVY;
    advert_scoreboard sb;
    int               cycle_count = 0;
    int               bytes_sent = 0;
    int               hold_left = 0;
    bit               held = 1'b0;

    router_advert_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_router_advert_parser failed");
            $finish;
        end
    end

    function automatic int tx_idle_pct(tb_phase_e p);
        case (p)
            PH_RX_HEAVY: return TX_IDLE_LOW;
            PH_TX_HEAVY: return RX_IDLE_HIGH;
            default:     return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct(tb_phase_e p);
        case (p)
            PH_RX_HEAVY: return RX_IDLE_HIGH;
            PH_TX_HEAVY: return TX_IDLE_LOW;
            default:     return 0;
        endcase
    endfunction

    // receiver: check popped records, random pop, one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            sb.check_record(result);
        end
        if (phase == PH_TX_HEAVY && !held)
        begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(0, 99) >= rx_idle_pct(phase));
        end
    end

    // one input request, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        rap_in_t req;
        req.data_byte = b;
        req.last = is_last;
        while ($urandom_range(0, 99) < tx_idle_pct(phase))
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= req;
        do
        begin
            @(posedge clk);
        end
        while (full);
        sb.take_byte(req);
        bytes_sent++;
    endtask

    task automatic send_message(input byte_q m);
        for (int i = 0; i < m.size(); i++)
        begin
            send_byte(m[i], i == m.size() - 1);
        end
    endtask

    task automatic write_reg(input rap_reg_e idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.write_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and let every expected record drain
    task automatic settle();
        push <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // append one option, cut after max_bytes
    function automatic void add_option(ref byte_q m, input logic [7:0] kind,
                                       input logic [7:0] len8, input logic [7:0] plen,
                                       input int max_bytes);
        int total;
        total = (len8 == 0) ? 2 : int'(len8) * 8;
        if (total > max_bytes)
        begin
            total = max_bytes;
        end
        for (int i = 0; i < total; i++)
        begin
            if (i == 0)
                m.push_back(kind);
            else if (i == 1)
                m.push_back(len8);
            else if (kind == OPT_PREFIX && i == PREFIX_LEN_OFF)
                m.push_back(plen);
            else
                m.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // mostly well-formed advertisements, some noise and broken ones
    function automatic void build_message(output byte_q m);
        int         shape;
        int         opts;
        int         pick;
        logic [7:0] len8;
        logic [7:0] plen;
        logic [7:0] kind;
        m = {};
        shape = $urandom_range(0, 99);
        if (shape < 10)
        begin
            // not an advertisement
            do
            begin
                kind = 8'($urandom_range(0, 255));
            end
            while (kind == RA_TYPE);
            m.push_back(kind);
            repeat ($urandom_range(0, 20)) m.push_back(8'($urandom_range(0, 255)));
            return;
        end
        m.push_back(RA_TYPE);
        if (shape < 18)
        begin
            // header cut short
            repeat ($urandom_range(0, 14)) m.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat (HEADER_BYTES - 1) m.push_back(8'($urandom_range(0, 255)));
        opts = $urandom_range(0, 3);
        for (int k = 0; k < opts; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                len8 = ($urandom_range(0, 4) != 0) ? 8'd4 : 8'($urandom_range(1, 6));
                case ($urandom_range(0, 7))
                    0:       plen = 8'd0;
                    1:       plen = 8'd64;
                    2:       plen = 8'd128;
                    3:       plen = 8'd255;
                    4:       plen = 8'd8;
                    5:       plen = 8'd72;
                    6:       plen = 8'd120;
                    default: plen = 8'($urandom_range(0, 255));
                endcase
                add_option(m, OPT_PREFIX, len8, plen, 64);
            end
            else if (pick < 65)
            begin
                len8 = ($urandom_range(0, 4) != 0) ? 8'd3 : 8'($urandom_range(1, 5));
                add_option(m, OPT_DNS, len8, 8'd0, 64);
            end
            else if (pick < 85)
            begin
                kind = 8'($urandom_range(0, 255));
                add_option(m, kind, 8'($urandom_range(1, 3)), 8'($urandom_range(0, 255)), 64);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       kind = OPT_PREFIX;
                    1:       kind = OPT_DNS;
                    default: kind = 8'($urandom_range(0, 255));
                endcase
                if (pick < 92)
                begin
                    // zero length, then junk that must be ignored
                    add_option(m, kind, 8'd0, 8'd0, 2);
                    repeat ($urandom_range(0, 6)) m.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    // any length, message ends inside the option
                    add_option(m, kind, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), $urandom_range(1, 40));
                end
                return;
            end
        end
    endfunction

    task automatic run_random(input int min_bytes, input int min_records);
        int    byte_start;
        int    rec_start;
        byte_q m;
        byte_start = bytes_sent;
        rec_start = sb.records_made;
        while (bytes_sent - byte_start < min_bytes || sb.records_made - rec_start < min_records)
        begin
            build_message(m);
            send_message(m);
        end
    endtask

    initial
    begin
        byte_q m;
        sb = new();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // receiver slow, sender mostly busy
        write_reg(REG_LINK_LOCAL_HIGH, '1);
        write_reg(REG_LINK_LOCAL_LOW, '0);
        phase = PH_RX_HEAVY;

        // advertisement of one byte: short header
        m = {RA_TYPE};
        send_message(m);
        // other message type, extreme bytes
        m = {8'hFF, 8'h00};
        send_message(m);
        // full header with extreme fields, then a zero-length option
        m = {RA_TYPE, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
             8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, OPT_DNS, 8'h00};
        send_message(m);

        run_random(100, 25);
        settle();

        // sender slow; receiver holds off at first so the queue fills
        write_reg(REG_LINK_LOCAL_HIGH, '0);
        write_reg(REG_LINK_LOCAL_LOW, '1);
        phase = PH_TX_HEAVY;
        m = {RA_TYPE};
        repeat (6) send_message(m);
        run_random(100, 25);
        settle();

        // no idling; starts with a full prefix option
        write_reg(REG_LINK_LOCAL_HIGH, {$urandom, $urandom});
        write_reg(REG_LINK_LOCAL_LOW, {$urandom, $urandom});
        phase = PH_STREAM;
        m = {RA_TYPE};
        repeat (HEADER_BYTES - 1) m.push_back(8'($urandom_range(0, 255)));
        add_option(m, OPT_PREFIX, 8'd4, 8'd64, 64);
        send_message(m);
        run_random(100, 25);
        settle();

        if (sb.errors == 0)
        begin
            $display("tb_router_advert_parser passed");
        end
        else
        begin
            $display("tb_router_advert_parser failed");
        end
        $finish;
    end

endmodule
